// ----- rtl/core/dnsenc_pkg.sv -----
// Shared types, constants and helpers for the DNS name label encoder.
package dnsenc_pkg;

    localparam int LABEL_MAX   = 62;
    localparam int STORE_DEPTH = 62;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(LABEL_MAX + 1);
    localparam int LEN_W       = 10;

    localparam logic [7:0]       DOT_CHAR = 8'd46;
    localparam logic [7:0]       END_CHAR = 8'd0;
    localparam logic [LEN_W-1:0] LEN_SAT  = 10'd1023;

    localparam int TUSER_DONE = 0;
    localparam int TUSER_OVF  = 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_DATA,
        S_TERM
    } t_state;

    // Saturating add of a byte count to the running encoded length.
    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [FILL_W:0]  b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {{(LEN_W - FILL_W){1'b0}}, b};
        if (s > {1'b0, LEN_SAT}) begin
            return LEN_SAT;
        end
        return s[LEN_W-1:0];
    endfunction

endpackage

// ----- rtl/core/dnsenc_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
module dnsenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dns_name_label_encoder_top.sv -----
// Top level of the DNS name label encoder: label buffer RAM, replay sequencer, output register.
//
//  Channel   Direction  Payload
//  s_*       in         tdata[7:0] = in_char
//  m_*       out        tdata[7:0] = out_byte, tdata[17:8] = total_length, tlast = run_last,
//                       tuser[0] = name_done, tuser[1] = label_overflow
//
// A label character is written to the label RAM; one beyond the label limit sets the
// overflow flag instead. Once taken, a dot replays the label (length byte, then one RAM
// read per character); a zero byte replays a non-empty label the same way and then
// emits the terminator, or only the terminator when the label is empty.
// The single read port of the label RAM sets the one-byte-per-cycle replay rate when unstalled.
// The input is not taken during a replay. Output stalls freeze the sequencer.
// Reset is synchronous, active low, and clears the fill count, length and flags.
module dns_name_label_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_char
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_byte, [17:8] total_length, [23:18] zero
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser    // [0] name_done, [1] label_overflow
);

    localparam int AW = dnsenc_pkg::ADDR_W;
    localparam int FW = dnsenc_pkg::FILL_W;
    localparam int LW = dnsenc_pkg::LEN_W;

    dnsenc_pkg::t_state r_state, n_state;

    logic [FW-1:0] r_fill;
    logic [AW-1:0] r_idx;
    logic [LW-1:0] r_emit;
    logic          r_ovf;
    logic          r_is_end;

    logic          r_m_valid;
    logic [7:0]    r_o_byte;
    logic [LW-1:0] r_o_total;
    logic          r_o_last;
    logic          r_o_done;
    logic          r_o_ovf;

    logic          s_acc, out_free, is_end_char, is_dot, is_plain, can_store;
    logic          last_byte;
    logic          ld;
    logic [7:0]    ob;
    logic [LW-1:0] ototal;
    logic          olast, odone;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    assign out_free    = !r_m_valid || i_m_tready;
    assign s_acc       = i_s_tvalid && (r_state == dnsenc_pkg::S_IDLE);
    assign is_end_char = (i_s_tdata == dnsenc_pkg::END_CHAR);
    assign is_dot      = (i_s_tdata == dnsenc_pkg::DOT_CHAR);
    assign is_plain    = !is_end_char && !is_dot;
    assign can_store   = (r_fill < FW'(dnsenc_pkg::LABEL_MAX));
    assign last_byte   = (FW'(r_idx) == (r_fill - FW'(1)));

    dnsenc_ram #(
        .WIDTH (8),
        .DEPTH (dnsenc_pkg::STORE_DEPTH)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && is_plain && can_store),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_s_tdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dnsenc_pkg::S_IDLE: begin
                if (s_acc && is_end_char) begin
                    n_state = (r_fill != '0) ? dnsenc_pkg::S_LEN : dnsenc_pkg::S_TERM;
                end else if (s_acc && is_dot) begin
                    n_state = dnsenc_pkg::S_LEN;
                end
            end
            dnsenc_pkg::S_LEN: begin
                if (out_free) begin
                    n_state = (r_fill == '0) ? dnsenc_pkg::S_IDLE : dnsenc_pkg::S_DATA;
                end
            end
            dnsenc_pkg::S_DATA: begin
                if (out_free && last_byte) begin
                    n_state = r_is_end ? dnsenc_pkg::S_TERM : dnsenc_pkg::S_IDLE;
                end
            end
            dnsenc_pkg::S_TERM: begin
                if (out_free) begin
                    n_state = dnsenc_pkg::S_IDLE;
                end
            end
            default: n_state = dnsenc_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: output register load and label RAM reads.
    always_comb begin
        ld     = 1'b0;
        ob     = '0;
        olast  = 1'b0;
        odone  = 1'b0;
        ototal = '0;
        re     = 1'b0;
        raddr  = '0;
        case (r_state)
            dnsenc_pkg::S_LEN: begin
                if (out_free) begin
                    ld    = 1'b1;
                    ob    = {{(8 - FW){1'b0}}, r_fill};
                    olast = (r_fill == '0);
                    re    = (r_fill != '0);
                end
            end
            dnsenc_pkg::S_DATA: begin
                if (out_free) begin
                    ld    = 1'b1;
                    ob    = rdata;
                    olast = last_byte && !r_is_end;
                    re    = !last_byte;
                    raddr = AW'(r_idx + AW'(1));
                end
            end
            dnsenc_pkg::S_TERM: begin
                if (out_free) begin
                    ld     = 1'b1;
                    olast  = 1'b1;
                    odone  = 1'b1;
                    ototal = dnsenc_pkg::sat_add(r_emit, (FW + 1)'(1));
                end
            end
            default: begin
                ld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dnsenc_pkg::S_IDLE;
            r_fill    <= '0;
            r_emit    <= '0;
            r_ovf     <= 1'b0;
            r_is_end  <= 1'b0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                if (is_plain) begin
                    if (can_store) begin
                        r_fill <= r_fill + FW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end else begin
                    r_is_end <= is_end_char;
                    if (is_dot || r_fill != '0) begin
                        r_emit <= dnsenc_pkg::sat_add(r_emit, {1'b0, r_fill} + (FW + 1)'(1));
                    end
                end
            end
            if (r_state == dnsenc_pkg::S_LEN && out_free) begin
                r_idx <= '0;
            end
            if (r_state == dnsenc_pkg::S_DATA && out_free) begin
                if (last_byte) begin
                    r_fill <= '0;
                end else begin
                    r_idx <= AW'(r_idx + AW'(1));
                end
            end
            if (r_state == dnsenc_pkg::S_TERM && out_free) begin
                r_fill <= '0;
                r_emit <= '0;
                r_ovf  <= 1'b0;
            end
            if (ld) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_o_byte  <= ob;
            r_o_total <= ototal;
            r_o_last  <= olast;
            r_o_done  <= odone;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_s_tready = (r_state == dnsenc_pkg::S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_o_total, r_o_byte};
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = {r_o_ovf, r_o_done};

    // The fill count never exceeds the label limit.
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(dnsenc_pkg::LABEL_MAX))
        else $error("label fill count beyond limit");

    // During replay the read index stays inside the stored label.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dnsenc_pkg::S_DATA) |-> (FW'(r_idx) < r_fill))
        else $error("replay index outside label");

    // A terminator always closes its run.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[dnsenc_pkg::TUSER_DONE]) |-> o_m_tlast)
        else $error("terminator without tlast");

    // After the terminator is loaded the name state is clear.
    a_name_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && odone) |=> (r_fill == '0 && r_emit == '0 && !r_ovf))
        else $error("name state not cleared after terminator");

    // The input is never taken while a replay is in progress.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dnsenc_pkg::S_IDLE) |-> !o_s_tready)
        else $error("input ready during replay");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the DNS name label encoder: random host names, stalls, scoreboard.
module tb;

    localparam int HOLD_LEN = 300;
    localparam int NAME_ITEMS_PER_PHASE = 12;

    typedef struct packed {
        logic [7:0]                   out_byte;
        logic                         run_last;
        logic                         name_done;
        logic [dnsenc_pkg::LEN_W-1:0] total_length;
        logic                         label_overflow;
    } t_enc_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] in_char
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // [7:0] out_byte, [17:8] total_length, [23:18] zero
    logic        o_m_tlast;
    logic [1:0]  o_m_tuser;   // [0] name_done, [1] label_overflow

    dns_name_label_encoder_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Characters waiting to be offered, and encoded bytes still owed by the block.
    logic [7:0] char_q[$];
    t_enc_byte  enc_q[$];
    int         items_queued = 0;
    int         mismatches = 0;

    // Predictor state.
    logic [7:0]                   label_buf[dnsenc_pkg::LABEL_MAX];
    int                           label_fill = 0;
    logic [dnsenc_pkg::LEN_W-1:0] name_len = '0;
    logic                         name_ovf = 1'b0;

    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    logic hold_go = 1'b0;
    int   hold_cnt = 0;
    logic s_fire = 1'b0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [dnsenc_pkg::LEN_W-1:0] len_plus(
        input logic [dnsenc_pkg::LEN_W-1:0] a, input int b);
        int s;
        s = int'(a) + b;
        return (s > int'(dnsenc_pkg::LEN_SAT)) ? dnsenc_pkg::LEN_SAT
                                               : s[dnsenc_pkg::LEN_W-1:0];
    endfunction

    task automatic emit(input logic [7:0] b, input logic done,
                        input logic [dnsenc_pkg::LEN_W-1:0] tot, input logic last);
        t_enc_byte e;
        e.out_byte       = b;
        e.run_last       = last;
        e.name_done      = done;
        e.total_length   = tot;
        e.label_overflow = name_ovf;
        enc_q.push_back(e);
    endtask

    task automatic flush_label(input logic ends_run);
        int k;
        emit(8'(label_fill), 1'b0, '0, ends_run && (label_fill == 0));
        for (k = 0; k < label_fill; k++) begin
            emit(label_buf[k], 1'b0, '0, ends_run && (k == label_fill - 1));
        end
        name_len   = len_plus(name_len, label_fill + 1);
        label_fill = 0;
    endtask

    // Works out the bytes that one accepted character causes.
    task automatic encode_char(input logic [7:0] c);
        if (c == dnsenc_pkg::END_CHAR) begin
            if (label_fill > 0) begin
                flush_label(1'b0);
            end
            name_len = len_plus(name_len, 1);
            emit(dnsenc_pkg::END_CHAR, 1'b1, name_len, 1'b1);
            label_fill = 0;
            name_len   = '0;
            name_ovf   = 1'b0;
        end else if (c == dnsenc_pkg::DOT_CHAR) begin
            flush_label(1'b1);
        end else if (label_fill < dnsenc_pkg::LABEL_MAX) begin
            label_buf[label_fill] = c;
            label_fill++;
        end else begin
            name_ovf = 1'b1;
        end
    endtask

    task automatic offer(input logic [7:0] c);
        char_q.push_back(c);
        items_queued++;
    endtask

    function automatic logic [7:0] label_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255, 1));
        end while (c == dnsenc_pkg::DOT_CHAR);
        return c;
    endfunction

    task automatic add_label(input int n);
        repeat (n) offer(label_char());
    endtask

    task automatic add_random_name();
        int nlab;
        int len;
        int pick;
        int i;
        nlab = $urandom_range(4, 0);
        for (i = 0; i < nlab; i++) begin
            pick = $urandom_range(99);
            if (pick < 85) len = $urandom_range(8, 0);
            else if (pick < 97) len = $urandom_range(20, 9);
            else len = $urandom_range(dnsenc_pkg::LABEL_MAX + 2, dnsenc_pkg::LABEL_MAX);
            add_label(len);
            if (i < nlab - 1 || $urandom_range(9) == 0) begin
                offer(dnsenc_pkg::DOT_CHAR);
            end
        end
        // Occasional stray bytes, which may include dots or an early end of name.
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(3, 1)) offer(8'($urandom_range(255, 0)));
        end
        offer(dnsenc_pkg::END_CHAR);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int target;
        @(posedge i_clk);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        target = items_queued + NAME_ITEMS_PER_PHASE;
        while (items_queued < target) begin
            add_random_name();
        end
        wait (char_q.size() == 0);
    endtask

    // Sender: a held item stays on the bus until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_fire) begin
            if (char_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= char_q.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Long output hold-off, started once while the sender keeps offering.
    always @(negedge i_clk) begin
        if (hold_go && hold_cnt < HOLD_LEN) begin
            hold_cnt <= hold_cnt + 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (hold_go && hold_cnt < HOLD_LEN)) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_enc_byte e;
        if (i_rst_n) begin
            s_fire <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                encode_char(i_s_tdata);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (enc_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected item: tdata=%h tlast=%b tuser=%b",
                                 o_m_tdata, o_m_tlast, o_m_tuser);
                    end
                end else begin
                    e = enc_q.pop_front();
                    if (o_m_tdata != {6'b0, e.total_length, e.out_byte}
                        || o_m_tlast != e.run_last
                        || o_m_tuser[dnsenc_pkg::TUSER_DONE] != e.name_done
                        || o_m_tuser[dnsenc_pkg::TUSER_OVF] != e.label_overflow) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp byte=%0d len=%0d last=%b done=%b ovf=%b",
                                     e.out_byte, e.total_length, e.run_last, e.name_done,
                                     e.label_overflow);
                            $display("          got byte=%0d len=%0d last=%b done=%b ovf=%b pad=%h",
                                     o_m_tdata[7:0], o_m_tdata[17:8], o_m_tlast,
                                     o_m_tuser[dnsenc_pkg::TUSER_DONE],
                                     o_m_tuser[dnsenc_pkg::TUSER_OVF],
                                     o_m_tdata[23:18]);
                        end
                    end
                end
            end
        end else begin
            s_fire <= 1'b0;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_m_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed names: empty name, leading and doubled dots with a trailing dot,
        // extreme and near-dot characters, and a label flushed by the end of name.
        offer(dnsenc_pkg::END_CHAR);
        offer(dnsenc_pkg::DOT_CHAR);
        offer(dnsenc_pkg::DOT_CHAR);
        offer(dnsenc_pkg::END_CHAR);
        offer(8'd255);
        offer(8'd1);
        offer(dnsenc_pkg::DOT_CHAR);
        offer(8'd45);
        offer(8'd47);
        offer(dnsenc_pkg::END_CHAR);
        offer(8'd127);
        offer(8'd128);
        offer(8'h55);
        offer(8'hAA);
        offer(dnsenc_pkg::DOT_CHAR);
        offer(dnsenc_pkg::END_CHAR);
        wait (char_q.size() == 0);

        // No idling: a name whose first label runs one character past the limit,
        // offered while the output is held off so the input backs up.
        @(posedge i_clk);
        add_label(dnsenc_pkg::LABEL_MAX + 1);
        offer(dnsenc_pkg::DOT_CHAR);
        add_label(3);
        offer(dnsenc_pkg::END_CHAR);
        hold_go = 1'b1;
        run_phase(0, 0);
        run_phase(65, 0);
        run_phase(0, 65);
        run_phase(38, 38);

        wait (char_q.size() == 0 && !i_s_tvalid);
        wait (enc_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && enc_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dnsenc_pkg.sv
rtl/core/dnsenc_ram.sv
rtl/core/dns_name_label_encoder_top.sv
tb/tb.sv
